FILE: hw/rtl/swe_pkg.sv
// ----------------------------------------------------------------------------
// swe_pkg: shared types and constants of the sine waveform evaluator
// Register indexes, field widths and the pipeline advance controls.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int TABLE_INDEX_BITS_DEF = 12;

  localparam int TIME_W  = 32;  // Q16.16 time, frequency, level, result
  localparam int GAIN_W  = 16;  // Q8.8 amplitude and scale
  localparam int SINE_W  = 16;  // signed Q1.15 sine
  localparam int MAG_W   = 15;  // unsigned table magnitude
  localparam int CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_START_TIME = 3'd0,
    CFG_AMPLITUDE  = 3'd1,
    CFG_FREQUENCY  = 3'd2,
    CFG_SCALE      = 3'd3,
    CFG_LEVEL      = 3'd4
  } cfg_reg_t;

  // one load enable per pipeline register stage
  typedef struct packed {
    logic dt;
    logic phase;
    logic rom;
    logic amp;
    logic gain;
    logic outp;
  } pl_ctl_t;

endpackage

FILE: hw/rtl/swe_phase.sv
// ----------------------------------------------------------------------------
// swe_phase: time offset and phase stages
// Stage one subtracts the start time, stage two forms the wrapped phase and
// keeps its top table-index bits.
// ----------------------------------------------------------------------------
module swe_phase #(
  parameter int TABLE_INDEX_BITS = swe_pkg::TABLE_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  swe_pkg::pl_ctl_t              ctl_i,
  input  logic [swe_pkg::TIME_W-1:0]    time_i,
  input  logic [swe_pkg::TIME_W-1:0]    start_i,
  input  logic [swe_pkg::TIME_W-1:0]    freq_i,
  output logic [TABLE_INDEX_BITS-1:0]   k_o
);

  logic [swe_pkg::TIME_W-1:0]  dt_r;
  logic [swe_pkg::TIME_W-1:0]  dt_nxt;
  logic [swe_pkg::TIME_W-1:0]  phase;
  logic [TABLE_INDEX_BITS-1:0] k_r;

  assign dt_nxt = time_i - start_i;
  // only the fractional turns matter: low word of the product
  assign phase  = freq_i * dt_r;

  always_ff @(posedge clk) begin
    if (ctl_i.dt) begin
      dt_r <= dt_nxt;
    end
    if (ctl_i.phase) begin
      k_r <= phase[swe_pkg::TIME_W-1 -: TABLE_INDEX_BITS];
    end
  end

  assign k_o = k_r;

endmodule

FILE: hw/rtl/swe_sine_rom.sv
// ----------------------------------------------------------------------------
// swe_sine_rom: quarter-wave sine table with registered read
// Folds the table index into the first quadrant and reads the magnitude;
// the sign travels beside it.
// ----------------------------------------------------------------------------
module swe_sine_rom #(
  parameter int TABLE_INDEX_BITS = swe_pkg::TABLE_INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  swe_pkg::pl_ctl_t            ctl_i,
  input  logic [TABLE_INDEX_BITS-1:0] k_i,
  output logic [swe_pkg::MAG_W-1:0]   mag_o,
  output logic                        neg_o
);

  localparam int QB   = TABLE_INDEX_BITS - 2;
  localparam int QLEN = 1 << QB;
  localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1846;

  typedef logic [swe_pkg::MAG_W-1:0] qtab_t [QLEN+1];

  // floor(a*b / 2^60), low 64 bits
  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // round(32767*sin(pi/2 * j/QLEN)) by a fixed-point Taylor series
  function automatic qtab_t build_tab();
    qtab_t           t;
    longint unsigned lowmask;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    lowmask = (64'd1 << QB) - 64'd1;
    for (int j = 0; j <= QLEN; j++) begin
      x = (HALF_PI_Q60 >> QB) * 64'(j)
        + (((HALF_PI_Q60 & lowmask) * 64'(j)) >> QB);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
      term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd110; sum = sum - term;
      term = mul_q60(term, x2) / 64'd156; sum = sum + term;
      term = mul_q60(term, x2) / 64'd210; sum = sum - term;
      term = mul_q60(term, x2) / 64'd272; sum = sum + term;
      term = mul_q60(term, x2) / 64'd342; sum = sum - term;
      term = mul_q60(term, x2) / 64'd420; sum = sum + term;
      term = mul_q60(term, x2) / 64'd506; sum = sum - term;
      term = mul_q60(term, x2) / 64'd600; sum = sum + term;
      r = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      t[j] = r[swe_pkg::MAG_W-1:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_tab();

  logic [1:0]                quad;
  logic [QB-1:0]             j;
  logic [QB:0]               addr;
  logic [swe_pkg::MAG_W-1:0] mag_r;
  logic                      neg_r;

  assign quad = k_i[TABLE_INDEX_BITS-1 -: 2];
  assign j    = k_i[QB-1:0];
  // odd quadrants read the table backward, from the peak entry down
  assign addr = quad[0] ? ((QB+1)'(QLEN) - {1'b0, j}) : {1'b0, j};

  always_ff @(posedge clk) begin
    if (ctl_i.rom) begin
      mag_r <= QTAB[addr];
      neg_r <= quad[1];
    end
  end

  assign mag_o = mag_r;
  assign neg_o = neg_r;

endmodule

FILE: hw/rtl/swe_gain.sv
// ----------------------------------------------------------------------------
// swe_gain: amplitude and scale products, level add and saturation
// Two multiplier stages, then the floor shift to Q16.16, the offset add and
// the clip to 32 bits in the output register.
// ----------------------------------------------------------------------------
module swe_gain (
  input  logic                              clk,
  input  swe_pkg::pl_ctl_t                  ctl_i,
  input  logic [swe_pkg::MAG_W-1:0]         mag_i,
  input  logic                              neg_i,
  input  logic signed [swe_pkg::GAIN_W-1:0] amp_i,
  input  logic signed [swe_pkg::GAIN_W-1:0] scale_i,
  input  logic signed [swe_pkg::TIME_W-1:0] level_i,
  output logic [swe_pkg::TIME_W-1:0]        wave_o,
  output logic                              sat_o
);

  localparam int P1_W  = swe_pkg::GAIN_W + swe_pkg::SINE_W;
  localparam int P2_W  = P1_W + swe_pkg::GAIN_W;
  localparam int SH_W  = swe_pkg::TIME_W + 1;
  localparam int SUM_W = swe_pkg::TIME_W + 2;

  logic signed [swe_pkg::SINE_W-1:0] sine;
  logic signed [P1_W-1:0]            p1_nxt;
  logic signed [P1_W-1:0]            p1_r;
  logic signed [P2_W-1:0]            p2_nxt;
  logic signed [P2_W-1:0]            p2_r;
  logic signed [P2_W-1:0]            shifted;
  logic signed [SUM_W-1:0]           sum;
  logic [swe_pkg::TIME_W-1:0]        wave_nxt;
  logic                              sat_nxt;
  logic [swe_pkg::TIME_W-1:0]        wave_r;
  logic                              sat_r;

  assign sine   = neg_i ? -$signed({1'b0, mag_i}) : $signed({1'b0, mag_i});
  assign p1_nxt = amp_i * sine;
  assign p2_nxt = p1_r * scale_i;

  // arithmetic shift rounds toward minus infinity; result fits in 33 bits
  assign shifted = p2_r >>> 15;
  assign sum = {shifted[SH_W-1], shifted[SH_W-1:0]}
             + {{2{level_i[swe_pkg::TIME_W-1]}}, level_i};

  always_comb begin
    wave_nxt = sum[swe_pkg::TIME_W-1:0];
    sat_nxt  = 1'b0;
    if (!sum[SUM_W-1] && (sum[SUM_W-2:SUM_W-3] != 2'b00)) begin
      wave_nxt = {1'b0, {(swe_pkg::TIME_W-1){1'b1}}};
      sat_nxt  = 1'b1;
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:SUM_W-3] != 2'b11)) begin
      wave_nxt = {1'b1, {(swe_pkg::TIME_W-1){1'b0}}};
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.amp) begin
      p1_r <= p1_nxt;
    end
    if (ctl_i.gain) begin
      p2_r <= p2_nxt;
    end
    if (ctl_i.outp) begin
      wave_r <= wave_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign wave_o = wave_r;
  assign sat_o  = sat_r;

endmodule

FILE: hw/rtl/sine_waveform_evaluator.sv
// ----------------------------------------------------------------------------
// sine_waveform_evaluator: pipelined fixed-point sinusoid evaluator
// Returns amplitude*sin(2*pi*frequency*(time-start))*scale+level per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one Q16.16 time sample per item (in_tdata[31:0] = time_req).
//   out_*  : one result per item, out_tdata[31:0] = wave_value (Q16.16),
//            out_tuser[0] = saturated.
//   cfg_*  : register writes, index 0 start_time, 1 amplitude, 2 frequency,
//            3 scale, 4 level; other indexes are ignored. cfg_ready is
//            always high. Write only while no item is in flight.
// Timing: six register stages (offset, phase multiply, table read,
//   amplitude multiply, scale multiply, sum and clip). An accepted item
//   passes them in that order and shows on out_tvalid once it sits in the
//   sum and clip stage. One item per cycle is sustained while out_tready
//   stays high; the rate is set by one item per stage.
// Stall: each stage holds while the next is full and stalled, so bubbles
//   close up; in_tready drops only when all six stages hold items.
// Reset: rst_n clears all valid bits and restores the register defaults
//   (amplitude and scale one, the rest zero). No clearing pass is needed.
// ----------------------------------------------------------------------------
module sine_waveform_evaluator #(
  parameter int TABLE_INDEX_BITS = swe_pkg::TABLE_INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // [31:0] time_req
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [31:0] wave_value
  output logic [0:0]                 out_tuser,  // [0] saturated
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [swe_pkg::CIDX_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);

  localparam int NSTG = 6;

  logic [swe_pkg::TIME_W-1:0]        start_r;
  logic signed [swe_pkg::GAIN_W-1:0] amp_r;
  logic [swe_pkg::TIME_W-1:0]        freq_r;
  logic signed [swe_pkg::GAIN_W-1:0] scale_r;
  logic signed [swe_pkg::TIME_W-1:0] level_r;

  logic [NSTG:1]                     vld_r;
  logic [NSTG:1]                     vld_nxt;
  logic [NSTG:1]                     en;
  swe_pkg::pl_ctl_t                  ctl;

  logic [TABLE_INDEX_BITS-1:0]       k;
  logic [swe_pkg::MAG_W-1:0]         mag;
  logic                              neg;
  logic [swe_pkg::TIME_W-1:0]        wave;
  logic                              sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      amp_r   <= 16'sd256;
      freq_r  <= '0;
      scale_r <= 16'sd256;
      level_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swe_pkg::CFG_START_TIME: start_r <= cfg_data;
        swe_pkg::CFG_AMPLITUDE:  amp_r   <= cfg_data[swe_pkg::GAIN_W-1:0];
        swe_pkg::CFG_FREQUENCY:  freq_r  <= cfg_data;
        swe_pkg::CFG_SCALE:      scale_r <= cfg_data[swe_pkg::GAIN_W-1:0];
        swe_pkg::CFG_LEVEL:      level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when its item moves on
  always_comb begin
    en[NSTG] = !vld_r[NSTG] || out_tready;
    for (int s = NSTG - 1; s >= 1; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
    vld_nxt[1] = en[1] ? in_tvalid : vld_r[1];
    for (int s = 2; s <= NSTG; s++) begin
      vld_nxt[s] = en[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  assign ctl.dt    = en[1];
  assign ctl.phase = en[2];
  assign ctl.rom   = en[3];
  assign ctl.amp   = en[4];
  assign ctl.gain  = en[5];
  assign ctl.outp  = en[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  swe_phase #(
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_phase (
    .clk     (clk),
    .ctl_i   (ctl),
    .time_i  (in_tdata),
    .start_i (start_r),
    .freq_i  (freq_r),
    .k_o     (k)
  );

  swe_sine_rom #(
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_rom (
    .clk   (clk),
    .ctl_i (ctl),
    .k_i   (k),
    .mag_o (mag),
    .neg_o (neg)
  );

  swe_gain u_gain (
    .clk     (clk),
    .ctl_i   (ctl),
    .mag_i   (mag),
    .neg_i   (neg),
    .amp_i   (amp_r),
    .scale_i (scale_r),
    .level_i (level_r),
    .wave_o  (wave),
    .sat_o   (sat)
  );

  assign in_tready  = en[1];
  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = wave;
  assign out_tuser  = sat;

  // a clipped result sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000))
    else $error("saturated result not at a rail");

  // an empty first stage never refuses an item
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[1] |-> in_tready)
    else $error("in_tready low with empty first stage");

  // a result appears only behind a full scale stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[NSTG-1]))
    else $error("result without an item in the stage before");

  // an accepted item is in stage one on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[1])
    else $error("accepted item lost at stage one");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sine waveform evaluator
// Streams time samples through the evaluator under several register settings
// and compares every result with a predictor that builds its own sine table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TIB          = swe_pkg::TABLE_INDEX_BITS_DEF;
  localparam int QB           = TIB - 2;
  localparam int QLEN         = 1 << QB;
  localparam int PIPE_DEPTH   = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int STEADY_ITEMS = 300;
  localparam int PHASES       = 17;
  localparam int PHASE_ITEMS  = 50;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  // indexes past the register file; writes there must be dropped
  localparam logic [swe_pkg::CIDX_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [swe_pkg::CIDX_W-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [swe_pkg::CIDX_W-1:0] CFG_SPARE_C = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } wave_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata   = '0;   // [31:0] time_req
  logic                       out_tvalid;
  logic                       out_tready = 1'b1;
  logic [31:0]                out_tdata;         // [31:0] wave_value
  logic [0:0]                 out_tuser;         // [0] saturated
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [swe_pkg::CIDX_W-1:0] cfg_index  = '0;
  logic [31:0]                cfg_data   = '0;

  sine_waveform_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the register file
  logic [31:0] cur_start = '0;
  logic [15:0] cur_amp   = 16'h0100;
  logic [31:0] cur_freq  = '0;
  logic [15:0] cur_scale = 16'h0100;
  logic [31:0] cur_level = '0;

  int    sine_quarter [0:QLEN];
  wave_t wave_q [$];
  bit    idle_on = 1'b0;
  int    n_items, n_checked, n_cfg, n_sat, n_errors, cycle;

  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'b0, a} * {64'b0, b};
    return prod[123:60];
  endfunction

  // Taylor series on Q60 angles, rounded to Q1.15
  function automatic void build_sine_quarter();
    logic [63:0] lowmask, x, x2, term, sum, r;
    lowmask = (64'd1 << QB) - 64'd1;
    for (int j = 0; j <= QLEN; j++) begin
      x = (HALF_PI_Q60 >> QB) * 64'(j) + (((HALF_PI_Q60 & lowmask) * 64'(j)) >> QB);
      x2 = q60_mul(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 12; n++) begin
        term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      r = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
      if (r > 64'd32767) r = 64'd32767;
      sine_quarter[j] = int'(r);
    end
  endfunction

  function automatic longint sine_at(input logic [TIB-1:0] k);
    logic [1:0]    quad;
    logic [QB-1:0] j;
    longint        v;
    quad = k[TIB-1:QB];
    j = k[QB-1:0];
    v = quad[0] ? sine_quarter[QLEN - int'(j)] : sine_quarter[int'(j)];
    return quad[1] ? -v : v;
  endfunction

  function automatic wave_t eval_wave(input logic [31:0] t);
    logic [31:0] dt, phase;
    longint      p, sum;
    wave_t       w;
    dt = t - cur_start;
    phase = cur_freq * dt;
    p = longint'($signed(cur_amp)) * sine_at(phase[31 -: TIB])
        * longint'($signed(cur_scale));
    sum = (p >>> 15) + longint'($signed(cur_level));
    w.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      w.sat = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      w.sat = 1'b1;
    end
    w.value = sum[31:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch at cycle %0d, %s: expected %h, got %h", cycle, what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    wave_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (out_tuser[0]) n_sat++;
      if (wave_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'h0, out_tdata);
      end else begin
        want = wave_q.pop_front();
        if (out_tdata !== want.value)
          report_mismatch("wave_value", want.value, out_tdata);
        if (out_tuser[0] !== want.sat)
          report_mismatch("saturated", {31'b0, want.sat}, {31'b0, out_tuser[0]});
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 14);
  end

  initial begin : watchdog
    cycle = 0;
    while (cycle < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_time(input logic [31:0] t);
    int gap;
    gap = (idle_on && $urandom_range(99) < 14) ? $urandom_range(1, 2) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    wave_q.push_back(eval_wave(t));
    n_items++;
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (wave_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swe_pkg::CIDX_W-1:0] idx, input logic [31:0] data);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      swe_pkg::CFG_START_TIME: cur_start = data;
      swe_pkg::CFG_AMPLITUDE:  cur_amp   = data[15:0];
      swe_pkg::CFG_FREQUENCY:  cur_freq  = data;
      swe_pkg::CFG_SCALE:      cur_scale = data[15:0];
      swe_pkg::CFG_LEVEL:      cur_level = data;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [31:0] start, input logic [15:0] amp,
                       input logic [31:0] freq, input logic [15:0] scl,
                       input logic [31:0] lvl);
    write_reg(swe_pkg::CFG_START_TIME, start);
    write_reg(swe_pkg::CFG_AMPLITUDE, {16'b0, amp});
    write_reg(swe_pkg::CFG_FREQUENCY, freq);
    write_reg(swe_pkg::CFG_SCALE, {16'b0, scl});
    write_reg(swe_pkg::CFG_LEVEL, lvl);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h0100;
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    logic [31:0] off;
    off = $urandom_range(0, 32'h0003_ffff);
    case ($urandom_range(9))
      0: return pick_word();
      1: return cur_start - 32'd1;
      2, 3, 4: return cur_start + off;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] freq, lvl;
    freq = ($urandom_range(2) == 0) ? pick_word()
         : 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;  // +-8 Hz
    lvl  = ($urandom_range(1) == 0) ? pick_word()
         : 32'($urandom_range(0, 32'h0001_ffff)) - 32'h0001_0000;
    setup(pick_word(), pick_gain(), freq, pick_gain(), lvl);
    if ($urandom_range(3) == 0)
      write_reg(CFG_SPARE_A + 3'($urandom_range(2)), $urandom);
  endtask

  // reset values: zero frequency gives zero phase, so the result is the level
  task automatic test_reset_defaults();
    send_time(32'h0);
    send_time(32'h7fff_ffff);
    send_time(32'h8000_0000);
    end_stream();
  endtask

  // 1 Hz, quarter turns; last two straddle one table step
  task automatic test_quadrants();
    setup(32'h0, 16'h0100, 32'h0001_0000, 16'h0100, 32'h0);
    send_time(32'h0000_0000);
    send_time(32'h0000_4000);
    send_time(32'h0000_8000);
    send_time(32'h0000_c000);
    send_time(32'h0000_000f);
    send_time(32'h0000_0010);
    end_stream();
  endtask

  // time minus start wraps around 2^32
  task automatic test_time_wrap();
    setup(32'h8000_0000, 16'h0300, 32'h0002_8000, 16'h0080, 32'h0000_1000);
    send_time(32'h7fff_ffff);
    send_time(32'h0000_0000);
    end_stream();
  endtask

  task automatic test_saturation();
    setup(32'h0, 16'h7fff, 32'h0001_0000, 16'h7fff, 32'h7fff_ffff);
    send_time(32'h0000_4000);
    send_time(32'h0000_0000);  // zero sine, level exactly at the top
    end_stream();
    write_reg(swe_pkg::CFG_AMPLITUDE, 32'h0000_8000);
    write_reg(swe_pkg::CFG_LEVEL, 32'h8000_0000);
    send_time(32'h0000_4000);
    end_stream();
  endtask

  task automatic test_negative_gains();
    setup(32'h0000_1234, 16'h8000, 32'hfffe_0000, 16'hff00, 32'hffff_0000);
    send_time(32'h0000_3000);
    send_time(32'hffff_ffff);
    end_stream();
    write_reg(swe_pkg::CFG_SCALE, 32'h0000_8000);
    send_time(32'h0000_5555);
    end_stream();
  endtask

  // writes past the last register leave the settings alone
  task automatic test_spare_index();
    write_reg(CFG_SPARE_A, 32'hffff_ffff);
    write_reg(CFG_SPARE_B, 32'h5a5a_a5a5);
    write_reg(CFG_SPARE_C, 32'h0000_0000);
    send_time(32'h0000_4000);
    end_stream();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_setup();
    for (int i = 0; i < STEADY_ITEMS; i++) send_time(pick_time());
    end_stream();
  endtask

  task automatic test_random_phases();
    idle_on = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off until the pipe has fully drained
        if (ph == 0 && i == PHASE_ITEMS / 2) begin
          end_stream();
          wait_for_results();
        end
        send_time(pick_time());
      end
      end_stream();
    end
  endtask

  initial begin
    build_sine_quarter();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_quadrants();
    test_time_wrap();
    test_saturation();
    test_negative_gains();
    test_spare_index();
    test_steady_stream();
    test_random_phases();

    wait_for_results();
    if (wave_q.size() != 0) begin
      n_errors += wave_q.size();
      $display("%0d expected results never arrived", wave_q.size());
    end
    $display("covered %0d time samples, %0d results checked (%0d clipped), %0d register writes",
             n_items, n_checked, n_sat, n_cfg);
    $display("settings ranged over extreme gains, levels, frequencies and time offsets");
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/swe_pkg.sv
hw/rtl/swe_phase.sv
hw/rtl/swe_sine_rom.sv
hw/rtl/swe_gain.sv
hw/rtl/sine_waveform_evaluator.sv
tb/sv/testbench.sv
